@@ hw/rtl/apcp_pkg.sv @@
// Shared types, character codes and helper functions for the antenna
// pointing command parser. No dependencies.
package apcp_pkg;

    // Frame buffer length and derived widths
    localparam int FRAME_LEN = 8;
    localparam int FILL_W    = $clog2(FRAME_LEN + 1);
    localparam int IDX_W     = $clog2(FRAME_LEN);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command characters
    localparam logic [7:0] CHAR_TOGGLE = 8'h6B;  // 'k'
    localparam logic [7:0] CHAR_STEP   = 8'h6E;  // 'n'
    localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'

    // Reset values of the configuration registers
    localparam logic [7:0] BEGIN_RESET = 8'd60;
    localparam logic [7:0] END_RESET   = 8'd62;

    // Limits of a valid frame
    localparam logic [9:0] AZ_MAX  = 10'd360;
    localparam logic [9:0] ALT_MAX = 10'd90;

    // Configuration register indexes
    localparam logic CFG_BEGIN = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_READ  = 2'd1,
        PH_ERROR = 2'd2
    } t_phase;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_toggle;
        logic       is_step;
        logic       is_begin;
        logic       is_end;
    } t_item;

    function automatic logic f_digit_ok(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Three digit decode: a leading non-digit keeps the old value,
    // later digits are added with 10 bit wrap
    function automatic logic [9:0] f_decode3(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] c2, input logic [9:0] old);
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [9:0] v;
        d0 = c0 - CHAR_ZERO;
        d1 = c1 - CHAR_ZERO;
        d2 = c2 - CHAR_ZERO;
        v  = old;
        if (f_digit_ok(c0)) begin
            v = 10'(d0[3:0]) * 10'd100;
        end
        if (f_digit_ok(c1)) begin
            v = v + 10'(d1[3:0]) * 10'd10;
        end
        if (f_digit_ok(c2)) begin
            v = v + 10'(d2[3:0]);
        end
        return v;
    endfunction

    function automatic logic [8:0] f_offset(input logic [1:0] dir);
        logic [8:0] off;
        unique case (dir)
            2'd0:    off = 9'd0;
            2'd1:    off = 9'd90;
            2'd2:    off = 9'd180;
            default: off = 9'd270;
        endcase
        return off;
    endfunction

endpackage

@@ hw/rtl/apcp_front.sv @@
// Front end: holds the begin/end character registers and classifies each
// received byte. Depends on apcp_pkg.
module apcp_front
    import apcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_rx_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_full,
    output logic       o_rx_stall,
    output logic       o_push,
    output t_item      o_item
);

    logic [7:0] r_begin_char;
    logic [7:0] r_end_char;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_char <= BEGIN_RESET;
            r_end_char   <= END_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BEGIN: r_begin_char <= i_cfg_data;
                CFG_END:   r_end_char   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Classify byte; begin wins over end
    always_comb begin
        o_item.rx_byte   = i_rx_byte;
        o_item.is_toggle = (i_rx_byte == CHAR_TOGGLE);
        o_item.is_step   = (i_rx_byte == CHAR_STEP);
        o_item.is_begin  = (i_rx_byte == r_begin_char);
        o_item.is_end    = (i_rx_byte == r_end_char) && (i_rx_byte != r_begin_char);
    end

    // Accept while the queue has room
    assign o_rx_stall = i_full;
    assign o_push     = i_rx_valid && !i_full;

endmodule

@@ hw/rtl/apcp_queue.sv @@
// Short FIFO of classified bytes between front and back end.
// Depends on apcp_pkg.
module apcp_queue
    import apcp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    // Store pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

@@ hw/rtl/apcp_back.sv @@
// Back end: mode, direction and frame state, frame buffer, decode and the
// result register. Depends on apcp_pkg.
module apcp_back
    import apcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_item             i_item,
    input  logic              i_res_stall,
    output logic              o_pop,
    output logic              o_res_valid,
    output logic [7:0]        o_echo_byte,
    output logic              o_calibration_mode,
    output logic [1:0]        o_facing,
    output logic [1:0]        o_frame_status,
    output logic              o_servo_update,
    output logic signed [9:0] o_servo_azimuth,
    output logic [6:0]        o_servo_altitude
);

    logic              r_mode;
    t_phase            r_phase;
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_buf [FRAME_LEN];
    logic [1:0]        r_dir;
    logic [9:0]        r_az;
    logic [9:0]        r_alt;
    logic              r_valid;

    logic              n_mode;
    t_phase            n_phase;
    logic [FILL_W-1:0] n_fill;
    logic [1:0]        n_dir;
    logic [9:0]        n_az;
    logic [9:0]        n_alt;
    logic              n_store;
    logic              n_update;
    logic [9:0]        n_saz;
    logic [6:0]        n_salt;
    logic              dec_ok;

    // Take the next transaction when the result register frees up
    assign o_pop = !i_empty && (!r_valid || !i_res_stall);

    // Next state for one byte
    always_comb begin
        n_mode   = r_mode ^ i_item.is_toggle;
        n_dir    = r_dir;
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_az     = r_az;
        n_alt    = r_alt;
        n_store  = 1'b0;
        n_update = 1'b0;
        n_saz    = '0;
        n_salt   = '0;
        dec_ok   = f_digit_ok(r_buf[0]) && f_digit_ok(r_buf[1]) && f_digit_ok(r_buf[2])
                && f_digit_ok(r_buf[4]) && f_digit_ok(r_buf[5]) && f_digit_ok(r_buf[6]);

        if (!i_item.is_toggle && i_item.is_step && r_mode) begin
            n_dir = r_dir + 2'd1;
        end

        if (!n_mode) begin
            priority if (i_item.is_begin) begin
                n_fill  = '0;
                n_phase = PH_READ;
            end else if (i_item.is_end) begin
                n_az  = f_decode3(r_buf[0], r_buf[1], r_buf[2], r_az);
                n_alt = f_decode3(r_buf[4], r_buf[5], r_buf[6], r_alt);
                if (r_phase != PH_ERROR && dec_ok && n_az <= AZ_MAX && n_alt <= ALT_MAX) begin
                    n_update = 1'b1;
                    n_saz    = n_az - 10'(f_offset(r_dir));
                    n_salt   = n_alt[6:0];
                    n_phase  = PH_WAIT;
                end else begin
                    n_phase = PH_ERROR;
                end
            end else if (r_phase == PH_READ && r_fill < FILL_W'(FRAME_LEN)) begin
                n_store = 1'b1;
                n_fill  = r_fill + 1'b1;
            end
        end
    end

    // Update state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_phase <= PH_WAIT;
            r_fill  <= '0;
            r_dir   <= 2'd0;
            r_az    <= '0;
            r_alt   <= '0;
            r_valid <= 1'b0;
            for (int k = 0; k < FRAME_LEN; k++) begin
                r_buf[k] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_mode  <= n_mode;
                r_phase <= n_phase;
                r_fill  <= n_fill;
                r_dir   <= n_dir;
                r_az    <= n_az;
                r_alt   <= n_alt;
                if (n_store) begin
                    r_buf[r_fill[IDX_W-1:0]] <= i_item.rx_byte;
                end
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each popped transaction
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_echo_byte        <= i_item.rx_byte;
            o_calibration_mode <= n_mode;
            o_facing           <= n_dir;
            o_frame_status     <= n_phase;
            o_servo_update     <= n_update;
            o_servo_azimuth    <= n_saz;
            o_servo_altitude   <= n_salt;
        end
    end

    assign o_res_valid = r_valid;

endmodule

@@ hw/rtl/antenna_pointing_command_parser_core.sv @@
// Top level of the antenna pointing command parser: front end, queue and
// back end. Depends on apcp_pkg, apcp_front, apcp_queue and apcp_back.
//
// One received byte per clock is accepted while the queue has room, and each
// is answered by exactly one result (the echoed byte plus mode, facing, frame
// status and servo angles). A byte passes through the queue into the result
// register: the front end classifies it against the begin and end characters
// into a two-entry queue, and the back end pops it once the result register is
// free, updating all parser state and decoding the frame for each byte, so
// throughput is one byte per cycle while the output does not stall. The input
// stalls only when the queue is full, which happens with a byte arriving every
// cycle under a sustained output stall. Configuration writes take effect at the
// next edge and must be done while no transaction is in flight.
module antenna_pointing_command_parser_core
    import apcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_rx_valid,
    input  logic [7:0]        i_rx_byte,
    output logic              o_rx_stall,
    output logic              o_res_valid,
    input  logic              i_res_stall,
    output logic [7:0]        o_echo_byte,
    output logic              o_calibration_mode,
    output logic [1:0]        o_facing,
    output logic [1:0]        o_frame_status,
    output logic              o_servo_update,
    output logic signed [9:0] o_servo_azimuth,
    output logic [6:0]        o_servo_altitude
);

    t_item push_item;
    t_item pop_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    apcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .i_full      (full),
        .o_rx_stall  (o_rx_stall),
        .o_push      (push),
        .o_item      (push_item)
    );

    apcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (pop_item)
    );

    apcp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (empty),
        .i_item             (pop_item),
        .i_res_stall        (i_res_stall),
        .o_pop              (pop),
        .o_res_valid        (o_res_valid),
        .o_echo_byte        (o_echo_byte),
        .o_calibration_mode (o_calibration_mode),
        .o_facing           (o_facing),
        .o_frame_status     (o_frame_status),
        .o_servo_update     (o_servo_update),
        .o_servo_azimuth    (o_servo_azimuth),
        .o_servo_altitude   (o_servo_altitude)
    );

    // A servo update always returns the frame to waiting
    a_update_waits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_servo_update |-> o_frame_status == PH_WAIT)
        else $error("servo update without return to waiting");

    // Angles are zero without an update
    a_angles_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_servo_update |-> o_servo_azimuth == '0 && o_servo_altitude == '0)
        else $error("servo angles nonzero without update");

    // No frame decode while calibrating
    a_no_update_calib : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_calibration_mode |-> !o_servo_update)
        else $error("servo update in calibration mode");

    // Updated altitude stays in range
    a_alt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_servo_update |-> o_servo_altitude <= 7'd90)
        else $error("servo altitude out of range");

endmodule
